// ===== hdl/glob_pattern_matcher_defines.svh =====
// assertion macros shared by the glob pattern matcher modules
`ifndef GLOB_PATTERN_MATCHER_DEFINES_SVH
`define GLOB_PATTERN_MATCHER_DEFINES_SVH

// same-cycle implication
`define GPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpm assertion failed");

// next-cycle implication
`define GPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpm assertion failed");

`endif

// ===== hdl/gpm_pkg.sv =====
// types and constants of the glob pattern matcher
`default_nettype none
package gpm_pkg;

    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_QMARK  = 8'h3F;
    localparam logic [7:0] C_LBRACK = 8'h5B;
    localparam logic [7:0] C_RBRACK = 8'h5D;
    localparam logic [7:0] C_BANG   = 8'h21;
    localparam logic [7:0] C_CARET  = 8'h5E;
    localparam logic [7:0] C_DASH   = 8'h2D;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_DOT    = 8'h2E;

    localparam int OPT_NOESC  = 0;
    localparam int OPT_PATH   = 1;
    localparam int OPT_PERIOD = 2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_FETCH, ST_EVAL, ST_PREV, ST_ESC,
        ST_SET0, ST_SET1, ST_ITEM_F, ST_ITEM, ST_LO_F, ST_LO,
        ST_DASH_F, ST_DASH, ST_HI_F, ST_HI, ST_TAIL_F, ST_TAIL, ST_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_START, OP_STAR, OP_HIT1, OP_HIT2, OP_HITSET,
        OP_MISS, OP_FAIL, OP_PASS, OP_LONG, OP_SETINIT, OP_NEG, OP_SIINC,
        OP_LO, OP_CMP, OP_RANGE, OP_PINC, OP_OUT
    } t_op;

    typedef enum logic [1:0] {PA_PPOS, PA_PPOS1, PA_SI, PA_SI1} t_pa;
    typedef enum logic {SA_SPOS, SA_PREV} t_sa;

    typedef struct packed {
        t_op  op;
        t_pa  pa;
        t_sa  sa;
        logic latch_c;
    } t_cmd;

    typedef struct packed {
        logic in_subj_done;
        logic too_long;
        logic out_free;
        logic p_end;
        logic p1_end;
        logic s_end;
        logic spos_zero;
        logic si_end;
        logic si1_lt;
        logic star_seen;
        logic set_match;
        logic esc_on;
        logic path_on;
        logic period_on;
        logic pq_star;
        logic pq_qmark;
        logic pq_lbr;
        logic pq_rbr;
        logic pq_bslash;
        logic pq_bang;
        logic pq_dash;
        logic eq_pc;
        logic esc_eq;
        logic c_slash;
        logic c_dot;
    } t_sts;

endpackage
`default_nettype wire

// ===== hdl/gpm_ram.sv =====
// generic single-write single-read ram with registered read data
`default_nettype none
module gpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/gpm_dp.sv =====
// datapath: stores, walk positions, set scan registers and result register
`default_nettype none
`include "glob_pattern_matcher_defines.svh"
module gpm_dp import gpm_pkg::*; #(
    parameter int PATTERN_DEPTH = 64,
    parameter int SUBJECT_DEPTH = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    input  wire logic [2:0] i_match_options,
    input  wire logic       i_req_type,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_is_last,
    input  wire logic       i_is_empty,
    input  wire logic       i_out_ready,
    input  wire t_cmd       i_cmd,
    output t_sts            o_sts,
    output logic            o_out_valid,
    output logic            o_match_found,
    output logic            o_too_long
);
    localparam int PW  = $clog2(PATTERN_DEPTH + 1);
    localparam int SW  = $clog2(SUBJECT_DEPTH + 1);
    localparam int PAW = $clog2(PATTERN_DEPTH);
    localparam int SAW = $clog2(SUBJECT_DEPTH);
    localparam logic [PW-1:0] P_MAX = PW'(PATTERN_DEPTH);
    localparam logic [SW-1:0] S_MAX = SW'(SUBJECT_DEPTH);

    logic [2:0]    r_opts;
    logic [PW-1:0] r_plen, r_ppos, r_star_pp, r_si;
    logic [SW-1:0] r_slen, r_spos, r_star_sp;
    logic          r_povf, r_sovf, r_pdone, r_star_seen, r_neg, r_set_hit;
    logic [7:0]    r_lo, r_c;
    logic          r_res_match, r_res_long, r_out_valid, r_out_match, r_out_long;

    logic [PW-1:0]  n_plen_base, ppos_inc, si_inc, star_pp_inc;
    logic [SW-1:0]  spos_inc, spos_dec, star_sp_inc;
    logic           p_restart, p_we, s_we;
    logic [PAW-1:0] p_raddr;
    logic [SAW-1:0] s_raddr;
    logic [7:0]     w_pq, w_sq;
    logic           load_p, load_s;

    assign load_p      = (i_cmd.op == OP_LOAD) && !i_req_type;
    assign load_s      = (i_cmd.op == OP_LOAD) && i_req_type;
    assign p_restart   = r_pdone || i_is_empty;
    assign n_plen_base = p_restart ? '0 : r_plen;
    assign p_we        = load_p && !i_is_empty && (n_plen_base < P_MAX);
    assign s_we        = load_s && !i_is_empty && (r_slen < S_MAX);
    assign ppos_inc    = r_ppos + 1'b1;
    assign star_pp_inc = r_ppos + 1'b1;
    assign si_inc      = r_si + 1'b1;
    assign spos_inc    = r_spos + 1'b1;
    assign spos_dec    = r_spos - 1'b1;
    assign star_sp_inc = r_star_sp + 1'b1;

    always_comb begin
        unique case (i_cmd.pa)
            PA_PPOS:  p_raddr = r_ppos[PAW-1:0];
            PA_PPOS1: p_raddr = ppos_inc[PAW-1:0];
            PA_SI:    p_raddr = r_si[PAW-1:0];
            PA_SI1:   p_raddr = si_inc[PAW-1:0];
            default:  p_raddr = r_ppos[PAW-1:0];
        endcase
        s_raddr = (i_cmd.sa == SA_PREV) ? spos_dec[SAW-1:0] : r_spos[SAW-1:0];
    end

    gpm_ram #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (n_plen_base[PAW-1:0]),
        .i_wdata (i_byte_value),
        .i_raddr (p_raddr),
        .o_rdata (w_pq)
    );

    gpm_ram #(.WIDTH(8), .DEPTH(SUBJECT_DEPTH)) u_subj_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_slen[SAW-1:0]),
        .i_wdata (i_byte_value),
        .i_raddr (s_raddr),
        .o_rdata (w_sq)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opts      <= '0;
            r_plen      <= '0;
            r_slen      <= '0;
            r_povf      <= 1'b0;
            r_sovf      <= 1'b0;
            r_pdone     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_opts <= i_match_options;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (load_p) begin
                if (p_restart) begin
                    r_povf <= 1'b0;
                end
                if (!i_is_empty && (n_plen_base >= P_MAX)) begin
                    r_povf <= 1'b1;
                end
                r_plen  <= p_we ? n_plen_base + 1'b1 : n_plen_base;
                r_pdone <= i_is_last || i_is_empty;
            end
            if (load_s) begin
                if (i_is_empty) begin
                    r_slen <= '0;
                    r_sovf <= 1'b0;
                end else if (s_we) begin
                    r_slen <= r_slen + 1'b1;
                end else begin
                    r_sovf <= 1'b1;
                end
            end
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
                r_slen      <= '0;
                r_sovf      <= 1'b0;
            end
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_c) begin
            r_c <= w_sq;
        end
        case (i_cmd.op)
            OP_START: begin
                r_ppos      <= '0;
                r_spos      <= '0;
                r_star_pp   <= '0;
                r_star_sp   <= '0;
                r_star_seen <= 1'b0;
            end
            OP_STAR: begin
                r_ppos      <= ppos_inc;
                r_star_pp   <= star_pp_inc;
                r_star_sp   <= r_spos;
                r_star_seen <= 1'b1;
            end
            OP_HIT1: begin
                r_ppos <= ppos_inc;
                r_spos <= spos_inc;
            end
            OP_HIT2: begin
                r_ppos <= r_ppos + PW'(2);
                r_spos <= spos_inc;
            end
            OP_HITSET: begin
                r_ppos <= si_inc;
                r_spos <= spos_inc;
            end
            OP_MISS: begin
                r_star_sp <= star_sp_inc;
                r_spos    <= star_sp_inc;
                r_ppos    <= r_star_pp;
            end
            OP_PINC: r_ppos <= ppos_inc;
            OP_SETINIT: begin
                r_si      <= ppos_inc;
                r_neg     <= 1'b0;
                r_set_hit <= 1'b0;
            end
            OP_NEG: begin
                r_neg <= 1'b1;
                r_si  <= si_inc;
            end
            OP_SIINC: r_si <= si_inc;
            OP_LO: begin
                r_lo <= w_pq;
                r_si <= si_inc;
            end
            OP_CMP: begin
                if (r_c == r_lo) begin
                    r_set_hit <= 1'b1;
                end
            end
            OP_RANGE: begin
                if ((r_c >= r_lo) && (r_c <= w_pq)) begin
                    r_set_hit <= 1'b1;
                end
                r_si <= r_si + PW'(2);
            end
            OP_FAIL: begin
                r_res_match <= 1'b0;
                r_res_long  <= 1'b0;
            end
            OP_PASS: begin
                r_res_match <= 1'b1;
                r_res_long  <= 1'b0;
            end
            OP_LONG: begin
                r_res_match <= 1'b0;
                r_res_long  <= 1'b1;
            end
            OP_OUT: begin
                r_out_match <= r_res_match;
                r_out_long  <= r_res_long;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.in_subj_done = i_req_type && (i_is_last || i_is_empty);
        o_sts.too_long     = r_povf || r_sovf;
        o_sts.out_free     = !r_out_valid || i_out_ready;
        o_sts.p_end        = r_ppos >= r_plen;
        o_sts.p1_end       = ({1'b0, r_ppos} + 1'b1) >= {1'b0, r_plen};
        o_sts.s_end        = r_spos >= r_slen;
        o_sts.spos_zero    = r_spos == '0;
        o_sts.si_end       = r_si >= r_plen;
        o_sts.si1_lt       = ({1'b0, r_si} + 1'b1) < {1'b0, r_plen};
        o_sts.star_seen    = r_star_seen;
        o_sts.set_match    = r_set_hit ^ r_neg;
        o_sts.esc_on       = !r_opts[OPT_NOESC];
        o_sts.path_on      = r_opts[OPT_PATH];
        o_sts.period_on    = r_opts[OPT_PERIOD];
        o_sts.pq_star      = w_pq == C_STAR;
        o_sts.pq_qmark     = w_pq == C_QMARK;
        o_sts.pq_lbr       = w_pq == C_LBRACK;
        o_sts.pq_rbr       = w_pq == C_RBRACK;
        o_sts.pq_bslash    = w_pq == C_BSLASH;
        o_sts.pq_bang      = (w_pq == C_BANG) || (w_pq == C_CARET);
        o_sts.pq_dash      = w_pq == C_DASH;
        o_sts.eq_pc        = w_pq == w_sq;
        o_sts.esc_eq       = w_pq == r_c;
        o_sts.c_slash      = w_sq == C_SLASH;
        o_sts.c_dot        = w_sq == C_DOT;
    end

    assign o_out_valid   = r_out_valid;
    assign o_match_found = r_out_match;
    assign o_too_long    = r_out_long;

    `GPM_ASSERT_NXT(a_miss_rewinds, i_clk, i_rst_n, i_cmd.op == OP_MISS, r_spos == r_star_sp)
    `GPM_ASSERT_IMP(a_hitset_in_range, i_clk, i_rst_n, i_cmd.op == OP_HITSET, r_si < r_plen)
endmodule
`default_nettype wire

// ===== hdl/gpm_ctrl.sv =====
// controller state machine for load, match walk and set scan
`default_nettype none
`include "glob_pattern_matcher_defines.svh"
module gpm_ctrl import gpm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);
    t_state r_state, n_state;
    logic   fire, qmiss, qprev;
    t_state miss_ns;
    t_op    miss_op;

    assign fire    = i_in_valid && (r_state == ST_IDLE);
    assign qmiss   = (i_sts.path_on && i_sts.c_slash)
                   || (i_sts.period_on && i_sts.c_dot && i_sts.spos_zero);
    assign qprev   = i_sts.period_on && i_sts.c_dot && i_sts.path_on;
    assign miss_ns = i_sts.star_seen ? ST_FETCH : ST_DONE;
    assign miss_op = i_sts.star_seen ? OP_MISS : OP_FAIL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (fire && i_sts.in_subj_done) n_state = ST_CHECK;
            ST_CHECK:  n_state = i_sts.too_long ? ST_DONE : ST_FETCH;
            ST_FETCH: begin
                if (i_sts.s_end)      n_state = ST_TAIL_F;
                else if (i_sts.p_end) n_state = miss_ns;
                else                  n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (i_sts.pq_star) begin
                    n_state = ST_FETCH;
                end else if (i_sts.pq_qmark) begin
                    if (qmiss)      n_state = miss_ns;
                    else if (qprev) n_state = ST_PREV;
                    else            n_state = ST_FETCH;
                end else if (i_sts.pq_lbr) begin
                    n_state = ST_SET0;
                end else if (i_sts.pq_bslash && i_sts.esc_on) begin
                    n_state = i_sts.p1_end ? ST_DONE : ST_ESC;
                end else begin
                    n_state = i_sts.eq_pc ? ST_FETCH : miss_ns;
                end
            end
            ST_PREV:   n_state = i_sts.c_slash ? miss_ns : ST_FETCH;
            ST_ESC:    n_state = i_sts.esc_eq ? ST_FETCH : miss_ns;
            ST_SET0:   n_state = i_sts.si_end ? miss_ns : ST_SET1;
            ST_SET1:   n_state = ST_ITEM_F;
            ST_ITEM_F: n_state = i_sts.si_end ? miss_ns : ST_ITEM;
            ST_ITEM: begin
                if (i_sts.pq_rbr)
                    n_state = i_sts.set_match ? ST_FETCH : miss_ns;
                else if (i_sts.pq_bslash && i_sts.esc_on)
                    n_state = i_sts.si1_lt ? ST_LO_F : miss_ns;
                else
                    n_state = ST_DASH_F;
            end
            ST_LO_F:   n_state = ST_LO;
            ST_LO:     n_state = ST_DASH_F;
            ST_DASH_F: n_state = i_sts.si1_lt ? ST_DASH : ST_ITEM_F;
            ST_DASH:   n_state = i_sts.pq_dash ? ST_HI_F : ST_ITEM_F;
            ST_HI_F:   n_state = ST_HI;
            ST_HI:     n_state = ST_ITEM_F;
            ST_TAIL_F: n_state = i_sts.p_end ? ST_DONE : ST_TAIL;
            ST_TAIL:   n_state = i_sts.pq_star ? ST_TAIL_F : ST_DONE;
            ST_DONE:   if (i_sts.out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.op      = OP_NONE;
        o_cmd.pa      = PA_PPOS;
        o_cmd.sa      = SA_SPOS;
        o_cmd.latch_c = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (fire) o_cmd.op = OP_LOAD;
            end
            ST_CHECK:  o_cmd.op = i_sts.too_long ? OP_LONG : OP_START;
            ST_FETCH: begin
                if (!i_sts.s_end && i_sts.p_end) o_cmd.op = miss_op;
            end
            ST_EVAL: begin
                o_cmd.latch_c = 1'b1;
                if (i_sts.pq_star) begin
                    o_cmd.op = OP_STAR;
                end else if (i_sts.pq_qmark) begin
                    if (qmiss)      o_cmd.op = miss_op;
                    else if (qprev) o_cmd.sa = SA_PREV;
                    else            o_cmd.op = OP_HIT1;
                end else if (i_sts.pq_lbr) begin
                    o_cmd.op = OP_SETINIT;
                end else if (i_sts.pq_bslash && i_sts.esc_on) begin
                    if (i_sts.p1_end) o_cmd.op = OP_FAIL;
                    else              o_cmd.pa = PA_PPOS1;
                end else begin
                    o_cmd.op = i_sts.eq_pc ? OP_HIT1 : miss_op;
                end
            end
            ST_PREV:   o_cmd.op = i_sts.c_slash ? miss_op : OP_HIT1;
            ST_ESC:    o_cmd.op = i_sts.esc_eq ? OP_HIT2 : miss_op;
            ST_SET0: begin
                if (i_sts.si_end) o_cmd.op = miss_op;
                else              o_cmd.pa = PA_SI;
            end
            ST_SET1:   if (i_sts.pq_bang) o_cmd.op = OP_NEG;
            ST_ITEM_F: begin
                if (i_sts.si_end) o_cmd.op = miss_op;
                else              o_cmd.pa = PA_SI;
            end
            ST_ITEM: begin
                if (i_sts.pq_rbr)
                    o_cmd.op = i_sts.set_match ? OP_HITSET : miss_op;
                else if (i_sts.pq_bslash && i_sts.esc_on)
                    o_cmd.op = i_sts.si1_lt ? OP_SIINC : miss_op;
                else
                    o_cmd.op = OP_LO;
            end
            ST_LO_F:   o_cmd.pa = PA_SI;
            ST_LO:     o_cmd.op = OP_LO;
            ST_DASH_F: begin
                if (i_sts.si1_lt) o_cmd.pa = PA_SI;
                else              o_cmd.op = OP_CMP;
            end
            ST_DASH:   if (!i_sts.pq_dash) o_cmd.op = OP_CMP;
            ST_HI_F:   o_cmd.pa = PA_SI1;
            ST_HI:     o_cmd.op = i_sts.pq_rbr ? OP_CMP : OP_RANGE;
            ST_TAIL_F: begin
                if (i_sts.p_end) o_cmd.op = OP_PASS;
                else             o_cmd.pa = PA_PPOS;
            end
            ST_TAIL:   o_cmd.op = i_sts.pq_star ? OP_PINC : OP_FAIL;
            ST_DONE:   if (i_sts.out_free) o_cmd.op = OP_OUT;
            default: ;
        endcase
    end

    `GPM_ASSERT_IMP(a_miss_needs_star, i_clk, i_rst_n, o_cmd.op == OP_MISS, i_sts.star_seen)
    `GPM_ASSERT_NXT(a_last_starts_check, i_clk, i_rst_n, fire && i_sts.in_subj_done, r_state == ST_CHECK)
endmodule
`default_nettype wire

// ===== hdl/glob_pattern_matcher.sv =====
// top level of the glob pattern matcher
//
// channel  | valid       | ready       | payload
// input    | i_in_valid  | o_in_ready  | i_req_type, i_byte_value, i_is_last, i_is_empty
// result   | o_out_valid | i_out_ready | o_match_found, o_too_long
// config   | i_cfg_valid | o_cfg_ready | i_match_options
//
// a pattern or subject byte is stored unless its store is full; no result for a non-final byte
// a final subject byte starts the match walk: a check state, then fetch and evaluate per
// pattern step, plus a state for an escape or a period check after a slash; a bracket set
// adds set head and item scan states; the walk repeats from the star on each backtrack
// input is held off during the walk and while a result waits for a free output slot
// reset clears lengths, flags and options; the stores are not cleared
`default_nettype none
module glob_pattern_matcher import gpm_pkg::*; #(
    parameter int PATTERN_DEPTH = 64,
    parameter int SUBJECT_DEPTH = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_req_type,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_is_last,
    input  wire logic       i_is_empty,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_match_found,
    output logic            o_too_long,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_match_options
);
    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    gpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    gpm_dp #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .SUBJECT_DEPTH (SUBJECT_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_match_options (i_match_options),
        .i_req_type      (i_req_type),
        .i_byte_value    (i_byte_value),
        .i_is_last       (i_is_last),
        .i_is_empty      (i_is_empty),
        .i_out_ready     (i_out_ready),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_out_valid     (o_out_valid),
        .o_match_found   (o_match_found),
        .o_too_long      (o_too_long)
    );
endmodule
`default_nettype wire
